@@ rtl/core/wsdefr_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame parser: parse phases, event codes,
// opcodes, the header length codes and byte counts, and the reset length cap.
// ----------------------------------------------------------------------------
package wsdefr_pkg;

   typedef logic [2:0] phase_type;
   typedef logic [1:0] event_type;
   typedef logic [3:0] opcode_type;

   localparam phase_type PH_HDR0 = 3'd0;
   localparam phase_type PH_HDR1 = 3'd1;
   localparam phase_type PH_EXT  = 3'd2;
   localparam phase_type PH_MASK = 3'd3;
   localparam phase_type PH_DATA = 3'd4;

   localparam event_type EV_TEXT     = 2'd0;
   localparam event_type EV_EMPTY    = 2'd1;
   localparam event_type EV_CLOSE    = 2'd2;
   localparam event_type EV_TOO_LONG = 2'd3;

   localparam opcode_type OP_TEXT  = 4'h1;
   localparam opcode_type OP_CLOSE = 4'h8;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES   = 4'd2;
   localparam logic [3:0] EXT64_BYTES   = 4'd8;
   localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

   localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

endpackage

@@ rtl/core/websocket_frame_deframer.sv @@
// Pipeline: an accepted request is held in the input register and its result
// in the result register; a request that causes no result is done when it
// leaves the input register.
// Throughput: one request per cycle; the per-byte parser step sits between
// the two registers and the result register stalls the input only when full.
// Reset (synchronous): the parser returns to the first header byte, no result
// is pending and the length cap returns to 8192.
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses client-to-server WebSocket frames one byte at a time, unmasks text
// payload bytes and reports empty text frames, close and oversize frames.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
   import wsdefr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_res,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_frame,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // Input register.
   logic       in_valid_ff;
   logic       in_kind_ff;
   logic [7:0] in_byte_ff;

   // Parser state.
   phase_type   phase_ff, phase_in;
   opcode_type  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  ext_ff, ext_in;
   logic [31:0] key_ff, key_in;
   logic [15:0] idx_ff, idx_in;
   logic        ended_ff, ended_in;
   logic [15:0] max_len_ff;

   // Result register.
   logic       rsp_valid_ff;
   event_type  rsp_event_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   logic        advance;
   logic        emit;
   event_type   ev;
   logic [7:0]  pbyte;
   logic        plast;
   logic        len_done;
   logic        pay_start;
   logic [63:0] len_v;
   logic [15:0] idx_next;
   logic [7:0]  key_byte;
   logic        data_last;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign idx_next  = idx_ff + 16'd1;
   assign data_last = {48'd0, idx_next} >= acc_ff;

   always_comb begin
      case (idx_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      acc_in    = acc_ff;
      ext_in    = ext_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      ended_in  = ended_ff;
      emit      = 1'b0;
      ev        = EV_TEXT;
      pbyte     = 8'd0;
      plast     = 1'b0;
      len_done  = 1'b0;
      pay_start = 1'b0;
      len_v     = acc_ff;
      if (advance) begin
         if (in_kind_ff) begin
            phase_in  = PH_HDR0;
            opcode_in = '0;
            mask_in   = 1'b0;
            acc_in    = '0;
            ext_in    = '0;
            key_in    = '0;
            idx_in    = '0;
            ended_in  = 1'b0;
         end else if (!ended_ff) begin
            case (phase_ff)
               PH_HDR0: begin
                  opcode_in = in_byte_ff[3:0];
                  phase_in  = PH_HDR1;
               end
               PH_HDR1: begin
                  mask_in = in_byte_ff[7];
                  if (in_byte_ff[6:0] == LEN_CODE_16 || in_byte_ff[6:0] == LEN_CODE_64) begin
                     ext_in   = (in_byte_ff[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
                     acc_in   = '0;
                     phase_in = PH_EXT;
                  end else begin
                     len_v    = {57'd0, in_byte_ff[6:0]};
                     acc_in   = len_v;
                     len_done = 1'b1;
                  end
               end
               PH_EXT: begin
                  len_v  = {acc_ff[55:0], in_byte_ff};
                  acc_in = len_v;
                  ext_in = ext_ff - 4'd1;
                  len_done = (ext_ff == 4'd1);
               end
               PH_MASK: begin
                  key_in    = {key_ff[23:0], in_byte_ff};
                  ext_in    = ext_ff - 4'd1;
                  pay_start = (ext_ff == 4'd1);
               end
               PH_DATA: begin
                  idx_in = idx_next;
                  if (data_last) begin
                     phase_in = PH_HDR0;
                  end
                  if (opcode_ff == OP_TEXT) begin
                     emit  = 1'b1;
                     ev    = EV_TEXT;
                     pbyte = in_byte_ff ^ key_byte;
                     plast = data_last;
                  end else if (data_last && opcode_ff == OP_CLOSE) begin
                     emit     = 1'b1;
                     ev       = EV_CLOSE;
                     ended_in = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_HDR0;
               end
            endcase

            // The cap is checked on the byte that completes the length.
            if (len_done) begin
               if (len_v > {48'd0, max_len_ff}) begin
                  ended_in = 1'b1;
                  phase_in = PH_HDR0;
                  emit     = 1'b1;
                  ev       = EV_TOO_LONG;
               end else begin
                  key_in = '0;
                  if (mask_in) begin
                     ext_in   = MASK_KEY_BYTES;
                     phase_in = PH_MASK;
                  end else begin
                     pay_start = 1'b1;
                  end
               end
            end

            if (pay_start) begin
               idx_in = '0;
               if (len_v != 64'd0) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_HDR0;
                  if (opcode_ff == OP_CLOSE) begin
                     ended_in = 1'b1;
                     emit     = 1'b1;
                     ev       = EV_CLOSE;
                  end else if (opcode_ff == OP_TEXT) begin
                     emit = 1'b1;
                     ev   = EV_EMPTY;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HDR0;
         opcode_ff    <= '0;
         mask_ff      <= 1'b0;
         acc_ff       <= '0;
         ext_ff       <= '0;
         key_ff       <= '0;
         idx_ff       <= '0;
         ended_ff     <= 1'b0;
         max_len_ff   <= MAX_LEN_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         acc_ff    <= acc_in;
         ext_ff    <= ext_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
         ended_ff  <= ended_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_data_byte;
      end
      if (advance && emit) begin
         rsp_event_ff <= ev;
         rsp_byte_ff  <= pbyte;
         rsp_last_ff  <= plast;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = rsp_event_ff;
   assign rsp_payload_byte  = rsp_byte_ff;
   assign rsp_last_of_frame = rsp_last_ff;

`ifndef SYNTHESIS
   // Only text payload bytes carry data or the last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_TEXT |-> rsp_payload_byte == 8'd0 && !rsp_last_of_frame)
      else $error("non-text result carries payload data");

   // An ended connection always waits at the first header byte.
   assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> phase_ff == PH_HDR0)
      else $error("ended connection left parser mid-frame");

   // A connection start returns the parser to its idle state.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_kind_ff |=> !ended_ff && phase_ff == PH_HDR0 && !rsp_valid)
      else $error("connection start did not clear the parser");

   // Payload is only streamed for lengths that passed the 16-bit cap.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> acc_ff[63:16] == 48'd0 && acc_ff != 64'd0)
      else $error("payload phase with out-of-range length");
`endif

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Drives client-to-server frame bytes and connection starts through the
// request channel under random idling. An in-bench parser predicts every
// event, and each response is checked against the oldest prediction. The
// length cap is rewritten between phases, including 0 and 65535.
// ----------------------------------------------------------------------------
module tb;
   import wsdefr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_START = 1'b1;
   localparam int   CYCLE_LIMIT = 800000;
   localparam int   NUM_PHASES  = 5;
   localparam int   PHASE_ITEMS = 150;
   localparam int   LONG_HOLD   = 250;

   localparam opcode_type OP_CONT   = 4'h0;
   localparam opcode_type OP_BINARY = 4'h2;
   localparam opcode_type OP_PING   = 4'h9;

   localparam int FORM_LEN7  = 0;
   localparam int FORM_LEN16 = 1;
   localparam int FORM_LEN64 = 2;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [4:0] gap;
   } link_req_type;

   typedef struct packed {
      event_type  ev;
      logic [7:0] data;
      logic       last;
   } deframe_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_res;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_of_frame;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   link_req_type       link_q[$];
   deframe_result_type deframed_q[$];
   link_req_type       next_req;
   deframe_result_type want;

   // Parser state mirrored by the predictor.
   phase_type   prs_phase;
   opcode_type  prs_opcode;
   logic        prs_masked;
   logic [63:0] prs_length;
   logic [3:0]  prs_bytes_left;
   logic [31:0] prs_key;
   logic [15:0] prs_index;
   logic        prs_closed;
   logic [15:0] prs_cap;

   int send_gap_max = 0;
   int recv_gap_max = 0;
   int send_wait = 0;
   int rsp_stall = 0;
   int hold_left = 0;
   int hold_requests = 0;
   int holds_done = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int pushed_items = 0;

   always #10 clock = ~clock;

   websocket_frame_deframer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_res     (rsp_event_res),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic void expect_event(event_type ev, logic [7:0] data, logic last);
      deframe_result_type r;
      r.ev = ev;
      r.data = data;
      r.last = last;
      deframed_q = {deframed_q, r};
   endfunction

   function automatic void clear_parser();
      prs_phase = PH_HDR0;
      prs_opcode = '0;
      prs_masked = 1'b0;
      prs_length = '0;
      prs_bytes_left = '0;
      prs_key = '0;
      prs_index = '0;
      prs_closed = 1'b0;
   endfunction

   function automatic void start_payload();
      prs_index = '0;
      if (prs_length != 0) begin
         prs_phase = PH_DATA;
      end else begin
         prs_phase = PH_HDR0;
         if (prs_opcode == OP_CLOSE) begin
            prs_closed = 1'b1;
            expect_event(EV_CLOSE, 8'd0, 1'b0);
         end else if (prs_opcode == OP_TEXT) begin
            expect_event(EV_EMPTY, 8'd0, 1'b0);
         end
      end
   endfunction

   // The cap is checked as soon as the length is complete, ahead of the key.
   function automatic void finish_length();
      if (prs_length > {48'd0, prs_cap}) begin
         prs_closed = 1'b1;
         prs_phase = PH_HDR0;
         expect_event(EV_TOO_LONG, 8'd0, 1'b0);
      end else begin
         prs_key = '0;
         if (prs_masked) begin
            prs_bytes_left = MASK_KEY_BYTES;
            prs_phase = PH_MASK;
         end else begin
            start_payload();
         end
      end
   endfunction

   function automatic void deframe_byte(logic kind, logic [7:0] b);
      int         key_sel;
      logic [7:0] plain;
      logic       last;
      if (kind == KIND_START) begin
         clear_parser();
         return;
      end
      if (prs_closed)
         return;
      case (prs_phase)
         PH_HDR0: begin
            prs_opcode = b[3:0];
            prs_phase = PH_HDR1;
         end
         PH_HDR1: begin
            prs_masked = b[7];
            prs_length = {57'd0, b[6:0]};
            if (b[6:0] == LEN_CODE_16 || b[6:0] == LEN_CODE_64) begin
               prs_bytes_left = (b[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
               prs_length = '0;
               prs_phase = PH_EXT;
            end else begin
               finish_length();
            end
         end
         PH_EXT: begin
            prs_length = {prs_length[55:0], b};
            prs_bytes_left = prs_bytes_left - 4'd1;
            if (prs_bytes_left == 0)
               finish_length();
         end
         PH_MASK: begin
            prs_key = {prs_key[23:0], b};
            prs_bytes_left = prs_bytes_left - 4'd1;
            if (prs_bytes_left == 0)
               start_payload();
         end
         PH_DATA: begin
            key_sel = 3 - int'(prs_index[1:0]);
            plain = b ^ prs_key[8*key_sel +: 8];
            prs_index = prs_index + 16'd1;
            last = ({48'd0, prs_index} >= prs_length);
            if (last)
               prs_phase = PH_HDR0;
            if (prs_opcode == OP_TEXT) begin
               expect_event(EV_TEXT, plain, last);
            end else if (last && prs_opcode == OP_CLOSE) begin
               prs_closed = 1'b1;
               expect_event(EV_CLOSE, 8'd0, 1'b0);
            end
         end
         default: prs_phase = PH_HDR0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready)
            deframe_byte(req_kind, req_data_byte);
         if (!req_valid || req_ready) begin
            if (link_q.size() > 0 && send_wait < int'(link_q[0].gap)) begin
               send_wait++;
               req_valid <= 1'b0;
            end else if (link_q.size() > 0) begin
               next_req = link_q.pop_front();
               req_valid <= 1'b1;
               req_kind <= next_req.kind;
               req_data_byte <= next_req.data;
               send_wait = 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor and checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (deframed_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response event %0d byte %0h last %0b", $time,
                        rsp_event_res, rsp_payload_byte, rsp_last_of_frame);
            end else begin
               want = deframed_q.pop_front();
               if (rsp_event_res != want.ev) begin
                  mismatch_count++;
                  $display("%0t: event expected %0d actual %0d", $time, want.ev,
                           rsp_event_res);
               end
               if (rsp_payload_byte != want.data) begin
                  mismatch_count++;
                  $display("%0t: payload_byte expected %0h actual %0h", $time, want.data,
                           rsp_payload_byte);
               end
               if (rsp_last_of_frame != want.last) begin
                  mismatch_count++;
                  $display("%0t: last_of_frame expected %0b actual %0b", $time, want.last,
                           rsp_last_of_frame);
               end
            end
            rsp_stall = $urandom_range(0, recv_gap_max);
         end
         if (holds_done < hold_requests) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic push_item(input logic kind, input logic [7:0] data);
      link_req_type r;
      r.kind = kind;
      r.data = data;
      r.gap = 5'($urandom_range(0, send_gap_max));
      link_q = {link_q, r};
      pushed_items++;
   endtask

   // Up to two bytes the parser must ignore, then a fresh connection.
   task automatic push_hangup();
      repeat ($urandom_range(0, 2)) push_item(KIND_BYTE, 8'($urandom));
      push_item(KIND_START, 8'($urandom));
   endtask

   // The form selects a 7-bit length, a 16-bit extended or a 64-bit extended one.
   // Only cut payload bytes are sent; a short frame is abandoned by a restart.
   task automatic push_frame(input opcode_type op, input logic masked, input logic [63:0] len,
                             input int form, input int cut);
      logic [6:0] code;
      int         n_ext;
      logic [3:0] flags;
      flags = 4'($urandom);
      code = (form == FORM_LEN7) ? len[6:0] : (form == FORM_LEN16) ? LEN_CODE_16 : LEN_CODE_64;
      n_ext = (form == FORM_LEN7) ? 0 : (form == FORM_LEN16) ? 2 : 8;
      push_item(KIND_BYTE, {flags, op});
      push_item(KIND_BYTE, {masked, code});
      for (int i = n_ext - 1; i >= 0; i--)
         push_item(KIND_BYTE, len[8*i +: 8]);
      if (len > {48'd0, prs_cap}) begin
         push_hangup();
         return;
      end
      if (masked)
         repeat (4) push_item(KIND_BYTE, 8'($urandom));
      repeat (cut) push_item(KIND_BYTE, 8'($urandom));
      if (cut < len)
         push_item(KIND_START, 8'($urandom));
      else if (op == OP_CLOSE)
         push_hangup();
   endtask

   task automatic push_random_frame();
      int          pick;
      int          near;
      int          form;
      int          cut;
      opcode_type  op;
      logic        masked;
      logic [63:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         repeat ($urandom_range(1, 4)) push_item(KIND_BYTE, 8'($urandom));
         push_item(KIND_START, 8'($urandom));
         return;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50)
         op = OP_TEXT;
      else if (pick < 62)
         op = OP_CLOSE;
      else if (pick < 72)
         op = OP_CONT;
      else if (pick < 80)
         op = OP_BINARY;
      else
         op = 4'($urandom);
      masked = ($urandom_range(0, 99) < 75);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         len = 64'($urandom_range(0, 12));
      end else if (pick < 80 && prs_cap <= 300) begin
         near = int'(prs_cap) + int'($urandom_range(0, 4)) - 2;
         len = (near < 0) ? 64'd0 : 64'(near);
      end else if (pick < 93) begin
         len = 64'($urandom_range(13, 300));
      end else begin
         len = {$urandom, $urandom} >> $urandom_range(0, 47);
         if (len <= {48'd0, prs_cap})
            len = prs_cap + 64'd1;
      end
      pick = $urandom_range(0, 99);
      if (len < 126)
         form = (pick < 80) ? FORM_LEN7 : (pick < 90) ? FORM_LEN16 : FORM_LEN64;
      else if (len < 65536)
         form = (pick < 70) ? FORM_LEN16 : FORM_LEN64;
      else
         form = FORM_LEN64;
      cut = (len <= {48'd0, prs_cap}) ? int'(len) : 0;
      if (cut > 0 && $urandom_range(0, 99) < 5)
         cut = $urandom_range(0, cut - 1);
      push_frame(op, masked, len, form, cut);
   endtask

   task automatic drain_link();
      while (link_q.size() != 0 || req_valid || deframed_q.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cap(input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      prs_cap = value;
      @(negedge clock);
   endtask

   initial begin
      logic [15:0] cap_value;
      prs_cap = MAX_LEN_RESET;
      clear_parser();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames under the reset cap.
      send_gap_max = 3;
      recv_gap_max = 3;
      push_item(KIND_BYTE, 8'h81);
      push_item(KIND_BYTE, 8'h02);
      push_item(KIND_BYTE, 8'h00);
      push_item(KIND_BYTE, 8'hFF);
      push_frame(OP_TEXT, 1'b1, 64'd2, FORM_LEN7, 2);
      push_frame(OP_TEXT, 1'b0, 64'd0, FORM_LEN7, 0);
      push_frame(OP_BINARY, 1'b0, 64'd1, FORM_LEN7, 1);
      push_frame(OP_PING, 1'b0, 64'd0, FORM_LEN7, 0);
      push_frame(OP_TEXT, 1'b0, 64'd1, FORM_LEN16, 1);
      push_frame(OP_TEXT, 1'b0, 64'hFFFF, FORM_LEN16, 0);
      push_frame(OP_CLOSE, 1'b0, 64'd0, FORM_LEN7, 0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_link();
         case (p)
            0: cap_value = 16'hFFFF;
            1: cap_value = 16'd0;
            2: cap_value = 16'($urandom_range(1, 40));
            3: cap_value = MAX_LEN_RESET;
            default: cap_value = 16'($urandom_range(41, 600));
         endcase
         write_cap(cap_value);
         send_gap_max = (p == 1 || p == 3) ? 19 : (p == 4) ? 5 : 0;
         recv_gap_max = (p == 0 || p == 3) ? 19 : (p == 4) ? 5 : 0;
         // Starve the response side while requests keep coming, so the
         // block fills up and has to push back on its input.
         if (p == 2)
            hold_requests++;
         cap_value = 16'(pushed_items + PHASE_ITEMS);
         while (pushed_items < int'(cap_value))
            push_random_frame();
      end

      drain_link();
      repeat (10) @(posedge clock);
      if (deframed_q.size() != 0)
         $display("%0t: %0d expected responses never arrived", $time, deframed_q.size());
      if (mismatch_count == 0 && deframed_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
